/* src/arc4_pkg.sv */
// arc4_pkg: shared types and constants for the ARC4 keystream generator.
// Holds the command codes, the sequencer state type and the table geometry.
// No dependencies.
package arc4_pkg;

	localparam int unsigned TABLE_DEPTH = 256;
	localparam int unsigned ADDR_W      = 8;
	localparam int unsigned DATA_W      = 8;
	localparam int unsigned KPOS_W      = 9;
	localparam int unsigned DROP_W      = 11;

	localparam logic [DROP_W-1:0] DROP_RESET = 11'd256;
	localparam logic [ADDR_W-1:0] LAST_KEY_POS = 8'hff;

	typedef enum logic [1:0] {
		OP_RESTART = 2'd0,
		OP_KEY     = 2'd1,
		OP_GEN     = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_NOT_KEYED = 1'b1;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_ADV  = 8'b0000_0010,
		ST_G1   = 8'b0000_0100,
		ST_G2   = 8'b0000_1000,
		ST_G3   = 8'b0001_0000,
		ST_K1   = 8'b0010_0000,
		ST_K2   = 8'b0100_0000,
		ST_K3   = 8'b1000_0000
	} state_t;

endpackage

/* src/arc4_keystream_generator.sv */
// arc4_keystream_generator: RC4 keystream generator with early-output discard.
// Generate and key items hold busy while their steps run; a generate result strobes in the
// same cycle that busy drops. No new item is taken while busy; results cannot stall.
// The final key item adds drop_count discarded steps; restart, ignored and not-keyed items
// leave busy low. Three dependent table reads and the swap set the step.
// Reset (arst_n low, async): table reads identity, indices cleared, not keyed, drop_count 256.
module arc4_keystream_generator
	import arc4_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        op,
	input  logic [7:0]        key_byte,
	// result channel, one-cycle strobe, cannot be stalled
	output logic              valid,
	output logic [7:0]        keystream_byte,
	output logic              status,
	// configuration
	input  logic              cfg_we,
	input  logic [10:0]       cfg_wdata
);

	// ------------------------------------------------------------------
	// Permutation memory: one synchronous read port, one write port.
	// A valid bit per entry stands in for the identity fill; restart
	// drops all valid bits at once.
	// ------------------------------------------------------------------
	logic [DATA_W-1:0]      mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vld_q;

	logic [ADDR_W-1:0] rd_addr;
	logic              we;
	logic [ADDR_W-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;

	logic [DATA_W-1:0] mem_dout_s1;
	logic              rd_vld_s1;
	logic [ADDR_W-1:0] rd_addr_s1;
	logic [DATA_W-1:0] rd_data;

	// Control and index state
	state_t            state_q;
	logic [ADDR_W-1:0] i_q;
	logic [ADDR_W-1:0] j_q;
	logic [KPOS_W-1:0] kp_q;
	logic              keyed_q;
	logic [DROP_W-1:0] drop_count_q;
	logic [DROP_W-1:0] drop_cnt_q;
	logic              emit_q;      // 1: step for a generate item, 0: discard step
	logic              valid_q;

	// Payload registers
	logic [DATA_W-1:0] a_q;         // S[i] or S[pos] captured on the first read
	logic [DATA_W-1:0] b_q;         // S[j] captured on the second read
	logic [DATA_W-1:0] kb_q;
	logic              fwd_j_q;     // output index hits j: value is a after the swap
	logic              fwd_i_q;     // output index hits i: value is b after the swap
	logic [DATA_W-1:0] ks_q;
	logic              status_q;

	logic              accept;
	op_t               op_in;
	logic [DATA_W-1:0] ks_next;

	assign accept = start && (state_q == ST_IDLE);
	assign op_in  = op_t'(op);
	assign busy   = (state_q != ST_IDLE);

	assign valid          = valid_q;
	assign keystream_byte = ks_q;
	assign status         = status_q;

	// An entry never written since restart holds its own index.
	assign rd_data = rd_vld_s1 ? mem_dout_s1 : rd_addr_s1;

	// Final output byte: the read was issued during the first swap write,
	// so patch in both halves of the swap.
	assign ks_next = fwd_j_q ? a_q : (fwd_i_q ? b_q : rd_data);

	// ------------------------------------------------------------------
	// Memory address and write control for each sequencer step
	// ------------------------------------------------------------------
	always_comb begin
		rd_addr = i_q + 8'd1;
		we      = 1'b0;
		wr_addr = i_q;
		wr_data = rd_data;
		case (state_q)
			ST_IDLE: begin
				// issue the first read of the item in its accept cycle
				if (op_in == OP_KEY) begin
					rd_addr = kp_q[ADDR_W-1:0];
				end else begin
					rd_addr = i_q + 8'd1;
				end
			end
			ST_ADV: begin
				rd_addr = i_q + 8'd1;
			end
			ST_G1: begin
				rd_addr = j_q + rd_data;
			end
			ST_G2: begin
				rd_addr = a_q + rd_data;
				we      = 1'b1;
				wr_addr = i_q;
				wr_data = rd_data;
			end
			ST_G3: begin
				we      = 1'b1;
				wr_addr = j_q;
				wr_data = a_q;
			end
			ST_K1: begin
				rd_addr = j_q + rd_data + kb_q;
			end
			ST_K2: begin
				we      = 1'b1;
				wr_addr = kp_q[ADDR_W-1:0];
				wr_data = rd_data;
			end
			ST_K3: begin
				we      = 1'b1;
				wr_addr = j_q;
				wr_data = a_q;
			end
			default: begin
				rd_addr = i_q;
			end
		endcase
	end

	// Memory array: write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		mem_dout_s1 <= mem[rd_addr];
		rd_addr_s1  <= rd_addr;
	end

	// Valid bits: restart drops them all, a write marks its entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= vld_q[rd_addr];
			if (accept && op_in == OP_RESTART) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_count_q <= DROP_RESET;
		end else if (cfg_we) begin
			drop_count_q <= cfg_wdata;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			i_q        <= '0;
			j_q        <= '0;
			kp_q       <= '0;
			keyed_q    <= 1'b0;
			drop_cnt_q <= '0;
			emit_q     <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op_in)
							OP_RESTART: begin
								i_q     <= '0;
								j_q     <= '0;
								kp_q    <= '0;
								keyed_q <= 1'b0;
							end
							OP_KEY: begin
								// drop key bytes once keying is complete
								if (!keyed_q) begin
									state_q <= ST_K1;
								end
							end
							OP_GEN: begin
								if (keyed_q) begin
									i_q     <= i_q + 8'd1;
									emit_q  <= 1'b1;
									state_q <= ST_G1;
								end else begin
									valid_q <= 1'b1;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_ADV: begin
					i_q     <= i_q + 8'd1;
					state_q <= ST_G1;
				end
				ST_G1: begin
					j_q     <= j_q + rd_data;
					state_q <= ST_G2;
				end
				ST_G2: begin
					state_q <= ST_G3;
				end
				ST_G3: begin
					if (emit_q) begin
						valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else if (drop_cnt_q == 11'd1) begin
						keyed_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						drop_cnt_q <= drop_cnt_q - 11'd1;
						state_q    <= ST_ADV;
					end
				end
				ST_K1: begin
					j_q     <= j_q + rd_data + kb_q;
					state_q <= ST_K2;
				end
				ST_K2: begin
					state_q <= ST_K3;
				end
				ST_K3: begin
					kp_q <= kp_q + 9'd1;
					if (kp_q[ADDR_W-1:0] == LAST_KEY_POS) begin
						// last key byte absorbed: clear indices, then discard unless drop_count is zero
						i_q <= '0;
						j_q <= '0;
						if (drop_count_q == '0) begin
							keyed_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							drop_cnt_q <= drop_count_q;
							emit_q     <= 1'b0;
							state_q    <= ST_ADV;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload captures
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kb_q     <= key_byte;
				ks_q     <= '0;
				status_q <= STATUS_NOT_KEYED;
			end
			ST_G1: begin
				a_q <= rd_data;
			end
			ST_G2: begin
				b_q     <= rd_data;
				fwd_j_q <= (rd_addr == j_q);
				fwd_i_q <= (rd_addr == i_q);
			end
			ST_G3: begin
				ks_q     <= ks_next;
				status_q <= STATUS_OK;
			end
			ST_K1: begin
				a_q <= rd_data;
			end
			default: begin
				kb_q <= kb_q;
			end
		endcase
	end

endmodule
